// ===== rtl/kwm_pkg.sv =====
// Shared types and constants for the k-way record merge block.
package kwm_pkg;
    localparam int WAYS_DEF  = 7;
    localparam int QDEPTH_DEF = 8;
    localparam int KEY_W = 14;
    localparam int PAY_W = 14;
    localparam int WAY_W = 3;
    localparam int CFG_W = 3;

    typedef struct packed {
        logic [WAY_W-1:0] way;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        logic             run_end;
    } t_in_item;

    typedef struct packed {
        logic [KEY_W-1:0] out_key;
        logic [PAY_W-1:0] out_payload;
        logic [WAY_W-1:0] source_way;
        logic             merge_done;
        logic             overflow;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push;       // store the captured record
        logic scan_start; // reset the head scan
        logic scan_step;  // compare the next way
        logic pop;        // emit the selected head
        logic clear;      // clear all run state
    } t_kwm_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic push_ok;    // record belongs to an active open run with space
        logic push_full;  // record targets a full queue
        logic scan_last;  // the current scan way is the last active one
        logic blocked;    // some active open run is empty
        logic any;        // at least one head was found
        logic done;       // popping the selected head ends the merge
    } t_kwm_sts;
endpackage

// ===== rtl/kway_record_merge_top.sv =====
// Top level of the k-way record merge block.
//
// Input channel: i_in_valid / o_in_stall carry one record per transaction,
// tagged with its run and an end-of-run mark. Output channel: o_out_valid /
// i_out_stall carry emitted records, each with source run, a final-record
// flag and an overflow flag for a dropped push into a full queue.
// Configuration: i_cfg_we with i_cfg_wdata sets the number of active runs.
//
// Each input transaction is captured and stored, then one head scan runs per
// emitted record; the serial compare over the run heads goes through the single
// record-memory read port. A push whose record frees no emission ends after one
// head scan. After the final record of the merge a clear state resets run state.
//
// Reset clears all queue pointers, counts and end marks and sets the active
// run count to 7; record memory contents are not cleared. While the receiver
// stalls, the result register holds and the block waits before the next pop.
module kway_record_merge_top
    import kwm_pkg::*;
#(
    parameter int WAYS   = WAYS_DEF,
    parameter int QDEPTH = QDEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data
);
    logic [CFG_W-1:0] active_ways;
    t_in_item         item;
    t_kwm_cmd         cmd;
    t_kwm_sts         sts;
    t_out_item        result;

    kwm_cfg u_cfg (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata, .o_active_ways(active_ways)
    );

    kwm_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_item(i_in_data),
        .o_item(item), .o_cmd(cmd), .i_sts(sts), .i_result(result),
        .o_out_valid, .i_out_stall, .o_out(o_out_data)
    );

    kwm_datapath #(.WAYS(WAYS), .QDEPTH(QDEPTH)) u_dp (
        .i_clk, .i_rst_n, .i_active_ways(active_ways), .i_item(item),
        .i_cmd(cmd), .o_sts(sts), .o_result(result)
    );
endmodule

// ===== rtl/kwm_datapath.sv =====
// Run queues, record memory and the serial minimum search.
module kwm_datapath
    import kwm_pkg::*;
#(
    parameter int WAYS   = WAYS_DEF,
    parameter int QDEPTH = QDEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_active_ways,
    input  t_in_item         i_item,
    input  t_kwm_cmd         i_cmd,
    output t_kwm_sts         o_sts,
    output t_out_item        o_result
);
    localparam int WI_W = $clog2(WAYS);
    localparam int QI_W = $clog2(QDEPTH);
    localparam int OC_W = $clog2(QDEPTH + 1);
    localparam int AD_W = $clog2(WAYS * QDEPTH);
    localparam int NW_W = $clog2(WAYS + 1);

    logic [KEY_W+PAY_W-1:0] r_mem [WAYS*QDEPTH];
    logic [QI_W-1:0] r_rd [WAYS];
    logic [QI_W-1:0] r_wr [WAYS];
    logic [OC_W-1:0] r_occ [WAYS];
    logic [WAYS-1:0] r_fin;

    logic [WI_W-1:0] r_scan;
    logic            r_any;
    logic            r_blocked;
    logic [WI_W-1:0] r_best;
    logic [KEY_W-1:0] r_best_key;
    logic [KEY_W+PAY_W-1:0] r_rdata;

    logic [NW_W-1:0] n_ways;
    logic [NW_W-1:0] cfg_ext;
    logic            way_in;
    logic [WI_W-1:0] wsel;
    logic [WAYS-1:0] done_vec;
    logic [KEY_W-1:0] scan_key;

    assign cfg_ext = NW_W'(i_active_ways);
    always_comb begin
        n_ways = cfg_ext;
        if (cfg_ext == '0) n_ways = NW_W'(1);
        if (cfg_ext > NW_W'(WAYS)) n_ways = NW_W'(WAYS);
    end

    assign way_in = (NW_W'(i_item.way) < n_ways);
    assign wsel   = WI_W'(i_item.way);

    // Memory read address follows the scan way, or the winner during pop setup.
    logic [WI_W-1:0] rd_way;
    assign rd_way = i_cmd.scan_step ? r_scan : r_best;
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[AD_W'(rd_way) * AD_W'(QDEPTH) + AD_W'(r_rd[rd_way])];
        if (i_cmd.push && way_in && !r_fin[wsel] && r_occ[wsel] != OC_W'(QDEPTH))
            r_mem[AD_W'(wsel) * AD_W'(QDEPTH) + AD_W'(r_wr[wsel])] <=
                {i_item.key, i_item.payload};
    end

    assign scan_key = r_rdata[KEY_W+PAY_W-1:PAY_W];

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            if (WI_W'(w) == r_best)
                done_vec[w] = r_fin[w] && (r_occ[w] == OC_W'(1));
            else
                done_vec[w] = (NW_W'(w) >= n_ways) || (r_fin[w] && r_occ[w] == '0);
        end
    end

    assign o_sts.push_ok   = way_in && !r_fin[wsel] && r_occ[wsel] != OC_W'(QDEPTH);
    assign o_sts.push_full = way_in && !r_fin[wsel] && r_occ[wsel] == OC_W'(QDEPTH);
    assign o_sts.scan_last = (NW_W'(r_scan) + NW_W'(1) >= n_ways);
    assign o_sts.blocked   = r_blocked;
    assign o_sts.any       = r_any;
    assign o_sts.done      = &done_vec;

    // The scan issues a read for r_scan in one cycle and compares the data the next.
    logic r_cmp_pending;
    logic [WI_W-1:0] r_cmp_way;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin <= '0;
            for (int w = 0; w < WAYS; w++) begin
                r_rd[w] <= '0; r_wr[w] <= '0; r_occ[w] <= '0;
            end
            r_scan <= '0; r_any <= 1'b0; r_blocked <= 1'b0; r_cmp_pending <= 1'b0;
        end else begin
            r_cmp_pending <= 1'b0;
            if (i_cmd.clear) begin
                r_fin <= '0;
                for (int w = 0; w < WAYS; w++) begin
                    r_rd[w] <= '0; r_wr[w] <= '0; r_occ[w] <= '0;
                end
            end else if (i_cmd.push && o_sts.push_ok) begin
                r_wr[wsel]  <= (r_wr[wsel] == QI_W'(QDEPTH-1)) ? '0 : r_wr[wsel] + 1'b1;
                r_occ[wsel] <= r_occ[wsel] + 1'b1;
                if (i_item.run_end) r_fin[wsel] <= 1'b1;
            end else if (i_cmd.pop) begin
                r_rd[r_best]  <= (r_rd[r_best] == QI_W'(QDEPTH-1)) ? '0 : r_rd[r_best] + 1'b1;
                r_occ[r_best] <= r_occ[r_best] - 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_scan <= '0; r_any <= 1'b0; r_blocked <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_cmp_pending <= 1'b1;
                r_cmp_way <= r_scan;
                if (!o_sts.scan_last) r_scan <= r_scan + 1'b1;
            end
            if (r_cmp_pending) begin
                if (r_occ[r_cmp_way] == '0) begin
                    if (!r_fin[r_cmp_way]) r_blocked <= 1'b1;
                end else if (!r_any || scan_key < r_best_key) begin
                    r_any <= 1'b1;
                    r_best <= r_cmp_way;
                    r_best_key <= scan_key;
                end
            end
        end
    end

    assign o_result.out_key     = r_rdata[KEY_W+PAY_W-1:PAY_W];
    assign o_result.out_payload = r_rdata[PAY_W-1:0];
    assign o_result.source_way  = WAY_W'(r_best);
    assign o_result.merge_done  = o_sts.done;
    assign o_result.overflow    = 1'b0;
endmodule

// ===== rtl/kwm_ctrl.sv =====
// Controller sequencing push, head scan, pop and output handshake.
module kwm_ctrl
    import kwm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_item,
    output t_in_item  o_item,
    output t_kwm_cmd  o_cmd,
    input  t_kwm_sts  i_sts,
    input  t_out_item i_result,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PUSH = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;
    localparam logic [2:0] S_HOLD = 3'd6;
    localparam logic [2:0] S_LAST = 3'd7;

    logic [2:0] r_state, n_state;
    t_in_item   r_item;
    logic       r_out_valid;
    t_out_item  r_out;
    logic       load_out;
    t_out_item  n_out;

    assign o_item      = r_item;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        load_out = 1'b0;
        n_out    = i_result;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_PUSH;
            S_PUSH: begin
                if (i_sts.push_full) begin
                    n_out = '{out_key: '0, out_payload: '0, source_way: r_item.way,
                              merge_done: 1'b0, overflow: 1'b1};
                    if (!r_out_valid) begin
                        load_out = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    o_cmd.push       = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) n_state = S_LAST;
            end
            // The compare of the last way lands at the end of this cycle.
            S_LAST: n_state = S_WAIT;
            S_WAIT: begin
                if (i_sts.blocked || !i_sts.any) n_state = S_IDLE;
                else n_state = S_READ;
            end
            S_READ: n_state = S_EMIT; // fetch the winner's record
            S_EMIT: begin
                if (!r_out_valid) begin
                    load_out  = 1'b1;
                    o_cmd.pop = 1'b1;
                    if (i_sts.done) n_state = S_HOLD;
                    else begin
                        o_cmd.scan_start = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_HOLD: begin
                o_cmd.clear = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) r_item <= i_item;
        if (load_out) r_out <= n_out;
    end
endmodule

// ===== rtl/kwmerge_top_unused.sv =====
// Configuration register for the number of merged runs.
module kwm_cfg
    import kwm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output logic [CFG_W-1:0] o_active_ways
);
    logic [CFG_W-1:0] r_active_ways;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_active_ways <= CFG_W'(7);
        else if (i_cfg_we) r_active_ways <= i_cfg_wdata;
    end
    assign o_active_ways = r_active_ways;
endmodule

// ===== sim/kwm_checker.sv =====
// Checker for the k-way record merge block: predicts emitted records and compares.
module kwm_checker
    import kwm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  t_in_item         i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  t_out_item        i_out_data,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NW = WAYS_DEF;
    localparam int QD = QDEPTH_DEF;

    logic [KEY_W-1:0] key_mem [NW][QD];
    logic [PAY_W-1:0] pay_mem [NW][QD];
    int unsigned      rd_ptr [NW];
    int unsigned      wr_ptr [NW];
    int unsigned      fill [NW];
    logic             ended [NW];
    logic [CFG_W-1:0] ways_cfg;
    t_out_item        expected_records[$];

    assign o_pending = expected_records.size();

    task automatic clear_runs();
        for (int w = 0; w < NW; w++) begin
            rd_ptr[w] = 0;
            wr_ptr[w] = 0;
            fill[w] = 0;
            ended[w] = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        o_fail_count++;
    endtask

    task automatic predict_merge(input t_in_item it);
        int unsigned n;
        int          cnt;
        logic        blocked;
        logic        found;
        int          best;
        logic        done;
        t_out_item   r;
        n = (ways_cfg == 0) ? 1 : ((ways_cfg > NW) ? NW : ways_cfg);
        cnt = 0;
        if (it.way < n && !ended[it.way]) begin
            if (fill[it.way] >= QD) begin
                r = '0;
                r.source_way = it.way;
                r.overflow = 1'b1;
                expected_records.push_back(r);
                return;
            end
            key_mem[it.way][wr_ptr[it.way]] = it.key;
            pay_mem[it.way][wr_ptr[it.way]] = it.payload;
            wr_ptr[it.way] = (wr_ptr[it.way] + 1) % QD;
            fill[it.way]++;
            if (it.run_end) ended[it.way] = 1'b1;
        end
        while (cnt < 56) begin
            blocked = 1'b0;
            found = 1'b0;
            best = 0;
            for (int w = 0; w < n; w++) begin
                if (fill[w] == 0) begin
                    if (!ended[w]) blocked = 1'b1;
                end else if (!found || key_mem[w][rd_ptr[w]] < key_mem[best][rd_ptr[best]]) begin
                    found = 1'b1;
                    best = w;
                end
            end
            if (blocked || !found) break;
            r = '0;
            r.out_key = key_mem[best][rd_ptr[best]];
            r.out_payload = pay_mem[best][rd_ptr[best]];
            r.source_way = best[WAY_W-1:0];
            rd_ptr[best] = (rd_ptr[best] + 1) % QD;
            fill[best]--;
            done = 1'b1;
            for (int w = 0; w < n; w++)
                if (!ended[w] || fill[w] != 0) done = 1'b0;
            r.merge_done = done;
            expected_records.push_back(r);
            cnt++;
            if (done) begin
                clear_runs();
                break;
            end
        end
    endtask

    initial begin
        o_fail_count = 0;
        ways_cfg = 3'd7;
        clear_runs();
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            clear_runs();
            ways_cfg = 3'd7;
        end else begin
            if (i_cfg_we) ways_cfg = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                if (expected_records.size() == 0) begin
                    report_mismatch("output transaction with nothing expected");
                end else begin
                    want = expected_records.pop_front();
                    if (i_out_data.out_key !== want.out_key)
                        report_mismatch($sformatf("key got %0d want %0d",
                            i_out_data.out_key, want.out_key));
                    if (i_out_data.out_payload !== want.out_payload)
                        report_mismatch($sformatf("payload got %0d want %0d",
                            i_out_data.out_payload, want.out_payload));
                    if (i_out_data.source_way !== want.source_way)
                        report_mismatch($sformatf("source way got %0d want %0d",
                            i_out_data.source_way, want.source_way));
                    if (i_out_data.merge_done !== want.merge_done)
                        report_mismatch($sformatf("merge_done got %0b want %0b",
                            i_out_data.merge_done, want.merge_done));
                    if (i_out_data.overflow !== want.overflow)
                        report_mismatch($sformatf("overflow got %0b want %0b",
                            i_out_data.overflow, want.overflow));
                end
            end
            if (i_in_valid && !i_in_stall) predict_merge(i_in_data);
        end
    end
endmodule

// ===== sim/tb_kway_record_merge_top.sv =====
// Testbench top for the k-way record merge block: stimulus, configuration and verdict.
module tb_kway_record_merge_top;
    import kwm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    logic             in_valid;
    logic             in_stall;
    t_in_item         in_data;
    logic             out_valid;
    logic             out_stall;
    t_out_item        out_data;
    int               fail_count;
    int               pending;
    int               cycle_count;
    logic             calm;
    int               sent_records;

    kway_record_merge_top i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    kwm_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver stalls in random bursts; none once the run is calm.
    always begin
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(negedge clk);
            out_stall <= 1'b0;
        end
    end

    // Valid stays high after the transaction until the next call or drain changes it;
    // the block stalls its input meanwhile, so nothing is taken twice.
    task automatic send_record(input int w, input int k, input int p, input bit e);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_data.way <= w[WAY_W-1:0];
        in_data.key <= k[KEY_W-1:0];
        in_data.payload <= p[PAY_W-1:0];
        in_data.run_end <= e;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        sent_records++;
    endtask

    task automatic drain_and_configure(input int ways);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_wdata <= ways[CFG_W-1:0];
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // One full merge: each active run gets a sorted run of records, interleaved.
    task automatic merge_session(input int n, input int maxlen);
        int len [8];
        int last [8];
        int left;
        int w;
        left = 0;
        for (int i = 0; i < 8; i++) begin
            len[i] = $urandom_range(1, maxlen);
            last[i] = $urandom_range(0, 50);
            if (i < n) left += len[i];
        end
        while (left > 0) begin
            w = $urandom_range(0, n - 1);
            if (len[w] == 0) continue;
            if ($urandom_range(0, 15) == 0) begin
                // noise: push a random record to a random way, which may be active, inactive or finished
                send_record($urandom_range(0, 7), $urandom_range(0, 16383),
                    $urandom_range(0, 16383), $urandom_range(0, 1));
            end
            last[w] += $urandom_range(0, 40);
            if (last[w] > 9998) last[w] = 9998;
            len[w]--;
            left--;
            send_record(w, last[w], $urandom_range(0, 9999), len[w] == 0);
        end
    endtask

    initial begin
        int ways;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cycle_count = 0;
        calm = 1'b0;
        sent_records = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: ties across ways and extreme fields.
        drain_and_configure(2);
        send_record(0, 16383, 16383, 1'b0);
        send_record(1, 16383, 0, 1'b0);
        for (int i = 0; i < 9; i++) send_record(0, 16383, i, 1'b0);
        send_record(1, 0, 9999, 1'b1);
        send_record(0, 16383, 5, 1'b1);
        send_record(1, 7, 7, 1'b1);
        drain_and_configure(0);
        send_record(3, 1, 1, 1'b1);
        send_record(0, 0, 16383, 1'b1);
        drain_and_configure(7);
        for (int w = 0; w < 7; w++) send_record(w, 9998, w, 1'b1);

        while (sent_records < 210) begin
            if (sent_records > 170) calm = 1'b1;
            ways = $urandom_range(0, 7);
            drain_and_configure(ways);
            merge_session(ways == 0 ? 1 : ways, ($urandom_range(0, 5) == 0) ? 12 : 5);
        end
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
